FILE: design/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// Shared widths, status codes and cell control types for the recency list.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int MAX_ENTRIES_DEF = 8;
  localparam int KEY_W           = 32;
  localparam int PAY_W           = 32;
  localparam int CNT_W           = 4;
  localparam int STAT_W          = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = 4'd6;

  localparam logic ACT_TOUCH = 1'b0;
  localparam logic ACT_SNAP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_HIT       = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSERT    = 3'd1;
  localparam logic [STAT_W-1:0] ST_EVICT     = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY_KEY = 3'd3;
  localparam logic [STAT_W-1:0] ST_DISABLED  = 3'd4;
  localparam logic [STAT_W-1:0] ST_SNAP      = 3'd5;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_PREV = 2'd1;
  localparam logic [1:0] CELL_NEXT = 2'd2;
  localparam logic [1:0] CELL_WRAP = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] probe_key;
  } cell_ctl_t;

endpackage

FILE: design/lru_cmd_if.sv
// ----------------------------------------------------------------------------
// lru_cmd_if
// Command channel: touch or snapshot request with key and payload.
// ----------------------------------------------------------------------------
interface lru_cmd_if;
  import lru_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [KEY_W-1:0] item_key;
  logic [PAY_W-1:0] item_payload;

  modport source (output valid, output action, output item_key, output item_payload,
                  input ready);
  modport sink (input valid, input action, input item_key, input item_payload,
                output ready);
endinterface

FILE: design/lru_rsp_if.sv
// ----------------------------------------------------------------------------
// lru_rsp_if
// Response channel: one beat per touch, one per entry on a snapshot (one if empty).
// ----------------------------------------------------------------------------
interface lru_rsp_if;
  import lru_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              entry_valid;
  logic [KEY_W-1:0]  entry_key;
  logic [PAY_W-1:0]  entry_payload;
  logic [CNT_W-1:0]  occupancy;
  logic              last;

  modport source (output valid, output status, output entry_valid, output entry_key,
                  output entry_payload, output occupancy, output last, input ready);
  modport sink (input valid, input status, input entry_valid, input entry_key,
                input entry_payload, input occupancy, input last, output ready);
endinterface

FILE: design/lru_cell.sv
// ----------------------------------------------------------------------------
// lru_cell
// One list position: holds a record, compares its key against the probe and
// takes its record from the newer neighbor, the older neighbor or the head.
// ----------------------------------------------------------------------------
module lru_cell (
  input  logic                      clk,
  input  lru_pkg::cell_ctl_t        ctl,
  input  logic [lru_pkg::KEY_W-1:0] prev_key,
  input  logic [lru_pkg::PAY_W-1:0] prev_payload,
  input  logic [lru_pkg::KEY_W-1:0] next_key,
  input  logic [lru_pkg::PAY_W-1:0] next_payload,
  input  logic [lru_pkg::KEY_W-1:0] wrap_key,
  input  logic [lru_pkg::PAY_W-1:0] wrap_payload,
  output logic [lru_pkg::KEY_W-1:0] key,
  output logic [lru_pkg::PAY_W-1:0] payload,
  output logic                      match
);
  import lru_pkg::*;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_HOLD: begin
      end
      CELL_PREV: begin
        key     <= prev_key;
        payload <= prev_payload;
      end
      CELL_NEXT: begin
        key     <= next_key;
        payload <= next_payload;
      end
      CELL_WRAP: begin
        key     <= wrap_key;
        payload <= wrap_payload;
      end
    endcase
  end

  assign match = (key == ctl.probe_key);

endmodule

FILE: design/lru_recent_list_unit.sv
// ----------------------------------------------------------------------------
// lru_recent_list_unit
// Most-recently-used list of keyed records held in a chain of cells, newest
// in cell 0. Touches match all cells at once; snapshots rotate the chain.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  cmd      | in  | action, item_key, item_payload
//  rsp      | out | status, entry_valid, entry_key, entry_payload, occupancy, last
//  wr_en    | in  | wr_data = list_capacity, written on any edge with wr_en high, rst low
//
//  Touches are accepted back to back while rsp drains.
//  A snapshot returns one beat per record, one rotation of the chain per beat,
//  or one empty beat; cmd is held off until the last beat has been loaded.
//  Reset clears the record count and sets the capacity to 6; cells are not
//  cleared. A stall on rsp holds the output register and backs up cmd.
// ----------------------------------------------------------------------------
module lru_recent_list_unit #(
  parameter int MAX_ENTRIES = lru_pkg::MAX_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  lru_cmd_if.sink                   cmd,
  lru_rsp_if.source                 rsp,
  input  logic                      wr_en,
  input  logic [lru_pkg::CNT_W-1:0] wr_data
);
  import lru_pkg::*;

  localparam int POS_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LIM_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  logic [CNT_W-1:0]  list_capacity;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              busy;
  logic [CNT_W-1:0]  left;

  logic              o_valid;
  logic [STAT_W-1:0] o_status;
  logic              o_entry_valid;
  logic [KEY_W-1:0]  o_key;
  logic [PAY_W-1:0]  o_pay;
  logic [CNT_W-1:0]  o_occ;
  logic              o_last;

  logic              load;
  logic [STAT_W-1:0] n_status;
  logic              n_entry_valid;
  logic [KEY_W-1:0]  n_key;
  logic [PAY_W-1:0]  n_pay;
  logic              n_last;

  logic [KEY_W-1:0]  cell_key [MAX_ENTRIES];
  logic [PAY_W-1:0]  cell_pay [MAX_ENTRIES];
  logic              cell_match [MAX_ENTRIES];
  cell_ctl_t         cell_ctl [MAX_ENTRIES];

  logic              out_free, take, touch_ok, snap_take, rotate_en;
  logic              hit_any;
  logic [POS_W-1:0]  hit_pos;
  logic [LIM_W-1:0]  shift_lim;
  logic [CNT_W-1:0]  eff_cap, wr_cap;
  logic [KEY_W-1:0]  evict_key;

  assign out_free  = !o_valid || rsp.ready;
  assign cmd.ready = !busy && out_free;
  assign take      = cmd.valid && cmd.ready;

  assign eff_cap = (32'(list_capacity) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : list_capacity;
  assign wr_cap  = (32'(wr_data) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : wr_data;

  assign touch_ok  = take && (cmd.action == ACT_TOUCH) && (cmd.item_key != '0)
                     && (eff_cap != '0);
  assign snap_take = take && (cmd.action == ACT_SNAP) && (cnt != '0);
  assign rotate_en = snap_take || (busy && out_free);

  always_comb begin
    hit_any   = 1'b0;
    hit_pos   = '0;
    evict_key = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (cell_match[i] && (i < 32'(cnt))) begin
        hit_any = 1'b1;
        hit_pos = hit_pos | POS_W'(i);
      end
      if (i + 1 == 32'(cnt)) begin
        evict_key = cell_key[i];
      end
    end
  end

  always_comb begin
    priority if (hit_any) begin
      shift_lim = LIM_W'(hit_pos);
    end else if (cnt < eff_cap) begin
      shift_lim = LIM_W'(cnt);
    end else begin
      shift_lim = LIM_W'(cnt - 1'b1);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cell_ctl[i].probe_key = cmd.item_key;
      cell_ctl[i].op        = CELL_HOLD;
      if (rotate_en) begin
        if (i + 1 < 32'(cnt)) begin
          cell_ctl[i].op = CELL_NEXT;
        end else if (i + 1 == 32'(cnt)) begin
          cell_ctl[i].op = CELL_WRAP;
        end
      end else if (touch_ok && (i <= 32'(shift_lim))) begin
        cell_ctl[i].op = CELL_PREV;
      end
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [KEY_W-1:0] pk, nk;
    logic [PAY_W-1:0] pp, np;
    if (g == 0) begin : g_head
      assign pk = cmd.item_key;
      assign pp = cmd.item_payload;
    end else begin : g_body
      assign pk = cell_key[g-1];
      assign pp = cell_pay[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_tail
      assign nk = cell_key[g];
      assign np = cell_pay[g];
    end else begin : g_inner
      assign nk = cell_key[g+1];
      assign np = cell_pay[g+1];
    end
    lru_cell u_cell (
      .clk          (clk),
      .ctl          (cell_ctl[g]),
      .prev_key     (pk),
      .prev_payload (pp),
      .next_key     (nk),
      .next_payload (np),
      .wrap_key     (cell_key[0]),
      .wrap_payload (cell_pay[0]),
      .key          (cell_key[g]),
      .payload      (cell_pay[g]),
      .match        (cell_match[g])
    );
  end

  always_comb begin
    cnt_next = cnt;
    if (wr_en) begin
      cnt_next = (cnt > wr_cap) ? wr_cap : cnt;
    end else if (touch_ok && !hit_any && (cnt < eff_cap)) begin
      cnt_next = cnt + 1'b1;
    end
  end

  always_comb begin
    load          = 1'b0;
    n_status      = ST_SNAP;
    n_entry_valid = 1'b0;
    n_key         = '0;
    n_pay         = '0;
    n_last        = 1'b1;
    if (take) begin
      load = 1'b1;
      priority if (cmd.action == ACT_SNAP) begin
        n_status = ST_SNAP;
        if (cnt != '0) begin
          n_entry_valid = 1'b1;
          n_key         = cell_key[0];
          n_pay         = cell_pay[0];
          n_last        = (cnt == CNT_W'(1));
        end
      end else if (cmd.item_key == '0) begin
        n_status = ST_EMPTY_KEY;
      end else if (eff_cap == '0) begin
        n_status = ST_DISABLED;
      end else if (hit_any) begin
        n_status = ST_HIT;
      end else if (cnt < eff_cap) begin
        n_status = ST_INSERT;
      end else begin
        n_status = ST_EVICT;
        n_key    = evict_key;
      end
    end else if (busy && out_free) begin
      load          = 1'b1;
      n_status      = ST_SNAP;
      n_entry_valid = 1'b1;
      n_key         = cell_key[0];
      n_pay         = cell_pay[0];
      n_last        = (left == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_capacity <= CAP_RESET;
      cnt           <= '0;
      busy          <= 1'b0;
      left          <= '0;
      o_valid       <= 1'b0;
    end else begin
      if (wr_en) begin
        list_capacity <= wr_data;
      end
      cnt <= cnt_next;
      if (snap_take && (cnt != CNT_W'(1))) begin
        busy <= 1'b1;
        left <= cnt - 1'b1;
      end else if (busy && out_free) begin
        left <= left - 1'b1;
        if (left == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
      if (load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_status      <= n_status;
      o_entry_valid <= n_entry_valid;
      o_key         <= n_key;
      o_pay         <= n_pay;
      o_occ         <= cnt_next;
      o_last        <= n_last;
    end
  end

  assign rsp.valid         = o_valid;
  assign rsp.status        = o_status;
  assign rsp.entry_valid   = o_entry_valid;
  assign rsp.entry_key     = o_key;
  assign rsp.entry_payload = o_pay;
  assign rsp.occupancy     = o_occ;
  assign rsp.last          = o_last;

endmodule

FILE: design/lru_checker.sv
// ----------------------------------------------------------------------------
// lru_checker
// Port-level checks on the recency list responses, bound to the top level.
// ----------------------------------------------------------------------------
module lru_checker #(
  parameter int MAX_ENTRIES = lru_pkg::MAX_ENTRIES_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [lru_pkg::STAT_W-1:0] status,
  input logic                       entry_valid,
  input logic [lru_pkg::KEY_W-1:0]  entry_key,
  input logic [lru_pkg::CNT_W-1:0]  occupancy,
  input logic                       last
);
  import lru_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry_key))
    else $error("response beat changed while stalled");

  a_touch_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_SNAP) |-> last && !entry_valid)
    else $error("touch response not a single final beat");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(occupancy) <= MAX_ENTRIES))
    else $error("occupancy above list size");

  a_empty_snap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_SNAP) && !entry_valid |-> last && (occupancy == '0))
    else $error("empty snapshot beat inconsistent");

  a_snap_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_SNAP) && !last |-> !cmd_ready)
    else $error("command taken in the middle of a snapshot");

endmodule

bind lru_recent_list_unit lru_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_lru_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_ready   (cmd.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .entry_valid (rsp.entry_valid),
  .entry_key   (rsp.entry_key),
  .occupancy   (rsp.occupancy),
  .last        (rsp.last)
);
